// File: rtl/depth_window_aggregator_core_macros.svh
// Assertion macros used by the checker file.
`ifndef DEPTH_WINDOW_AGGREGATOR_CORE_MACROS_SVH
`define DEPTH_WINDOW_AGGREGATOR_CORE_MACROS_SVH

// Checked only outside reset.
`define DWA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DWA_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dwa_pkg.sv
// Shared types and constants of the depth window aggregator.
package dwa_pkg;

    localparam int VAL_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_LOW   = 2'd0;
    localparam logic [1:0] REG_WINDOW_HIGH  = 2'd1;
    localparam logic [1:0] REG_AGG_MODE     = 2'd2;
    localparam logic [1:0] REG_NO_DATA_CODE = 2'd3;

    // aggregation modes
    localparam logic [1:0] MODE_MEAN     = 2'd0;
    localparam logic [1:0] MODE_MAX      = 2'd1;
    localparam logic [1:0] MODE_MIN      = 2'd2;
    localparam logic [1:0] MODE_MEAN_ALL = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] depth;
        logic signed [VAL_W-1:0] sample_value;
        logic                    last_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] aggregate;
        logic                    empty_res;
    } out_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] window_low;
        logic signed [VAL_W-1:0] window_high;
        logic [1:0]              agg_mode;
        logic signed [VAL_W-1:0] no_data_code;
    } cfg_t;

    // classified sample as it travels from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic                    ok;
        logic                    last;
    } qentry_t;

endpackage

// File: rtl/dwa_front.sv
// Front end: accepts input words and marks whether each sample qualifies.
module dwa_front
(
    input  logic             push,
    output logic             full,
    input  dwa_pkg::in_word_t in_data,
    input  dwa_pkg::cfg_t    cfg,
    input  logic             queue_full,
    output logic             q_push,
    output dwa_pkg::qentry_t q_entry
);

    logic depth_ok;
    logic value_ok;

    always_comb
    begin
        depth_ok = (in_data.depth != cfg.no_data_code)
                && (in_data.depth >= cfg.window_low)
                && (in_data.depth < cfg.window_high);
        value_ok = (cfg.agg_mode == dwa_pkg::MODE_MEAN_ALL)
                || (in_data.sample_value != cfg.no_data_code);
        q_entry.sample_value = in_data.sample_value;
        q_entry.ok           = depth_ok && value_ok;
        q_entry.last         = in_data.last_sample;
    end

    assign full   = queue_full;
    assign q_push = push && !queue_full;

endmodule

// File: rtl/dwa_queue.sv
// Short queue of classified samples between front and back.
module dwa_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dwa_pkg::qentry_t din,
    output logic             full,
    input  logic             pop,
    output dwa_pkg::qentry_t dout,
    output logic             empty
);

    dwa_pkg::qentry_t                 entries [dwa_pkg::QUEUE_DEPTH];
    logic [dwa_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dwa_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [dwa_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dwa_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [dwa_pkg::QCNT_W-1:0]       count_reg;
    logic [dwa_pkg::QCNT_W-1:0]       count_next;
    logic                             do_push;
    logic                             do_pop;

    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= din;
        end
    end

    assign dout  = entries[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == dwa_pkg::QCNT_W'(dwa_pkg::QUEUE_DEPTH));

endmodule

// File: rtl/dwa_div.sv
// Iterative restoring divider for the mean: signed sum over unsigned count.
module dwa_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 17
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [NUM_W-1:0]         num,
    input  logic [DEN_W-1:0]                den,
    output logic                            done,
    output logic signed [dwa_pkg::VAL_W-1:0] quotient
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [ITER_W-1:0]    iter_reg;
    logic [ITER_W-1:0]    iter_next;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [NUM_W-1:0]     quo_reg;
    logic [NUM_W-1:0]     quo_next;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     den_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [DEN_W:0]       rem_shift;
    logic                 fits;
    logic [DEN_W:0]       rem_sub;
    logic [NUM_W-1:0]     num_mag;

    always_comb
    begin
        num_mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num_mag;
            den_next  = den;
            neg_next  = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, MSB first
            rem_next  = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // truncated quotient always fits in 32 bits
    assign quotient = neg_reg ? -$signed(quo_reg[dwa_pkg::VAL_W-1:0])
                              : $signed(quo_reg[dwa_pkg::VAL_W-1:0]);
    assign done     = done_reg;

endmodule

// File: rtl/dwa_back.sv
// Back end: accumulates sum, count and extreme, forms and holds the result word.
module dwa_back #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SUM_W       = 48,
    parameter int CNT_W       = 17
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dwa_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  dwa_pkg::qentry_t   q_entry,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output dwa_pkg::out_word_t out_data
);

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic signed [SUM_W-1:0]         sum_reg;
    logic signed [SUM_W-1:0]         sum_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;
    logic signed [dwa_pkg::VAL_W-1:0] ext_reg;
    logic signed [dwa_pkg::VAL_W-1:0] ext_next;
    logic signed [dwa_pkg::VAL_W-1:0] res_reg;
    logic signed [dwa_pkg::VAL_W-1:0] res_next;
    logic                            res_empty_reg;
    logic                            res_empty_next;
    dwa_pkg::out_word_t              out_reg;
    dwa_pkg::out_word_t              out_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic                            take;
    logic signed [dwa_pkg::VAL_W-1:0] v;
    logic signed [SUM_W-1:0]         sum_upd;
    logic [CNT_W-1:0]                cnt_upd;
    logic signed [dwa_pkg::VAL_W-1:0] ext_upd;
    logic                            out_free;
    logic                            load;
    logic                            div_start;
    logic                            div_done;
    logic signed [dwa_pkg::VAL_W-1:0] div_quo;

    dwa_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (sum_upd),
        .den      (cnt_upd),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        v    = q_entry.sample_value;
        take = q_entry.ok && (cnt_reg < CNT_W'(MAX_SAMPLES));

        sum_upd = sum_reg;
        cnt_upd = cnt_reg;
        ext_upd = ext_reg;
        if (take)
        begin
            sum_upd = sum_reg + {{(SUM_W-dwa_pkg::VAL_W){v[dwa_pkg::VAL_W-1]}}, v};
            cnt_upd = cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                ext_upd = v;
            end
            else if (cfg.agg_mode == dwa_pkg::MODE_MAX && v > ext_reg)
            begin
                ext_upd = v;
            end
            else if (cfg.agg_mode == dwa_pkg::MODE_MIN && v < ext_reg)
            begin
                ext_upd = v;
            end
        end

        out_free       = !out_valid_reg || pop;
        load           = 1'b0;
        div_start      = 1'b0;
        q_pop          = 1'b0;
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ext_next       = ext_reg;
        res_next       = res_reg;
        res_empty_next = res_empty_reg;

        unique case (state_reg)
            ST_ACC:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_entry.last)
                    begin
                        sum_next = '0;
                        cnt_next = '0;
                        ext_next = '0;
                        if (cnt_upd == '0)
                        begin
                            res_next       = cfg.no_data_code;
                            res_empty_next = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        else if (cfg.agg_mode == dwa_pkg::MODE_MAX
                              || cfg.agg_mode == dwa_pkg::MODE_MIN)
                        begin
                            res_next       = ext_upd;
                            res_empty_next = 1'b0;
                            state_next     = ST_EMIT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        sum_next = sum_upd;
                        cnt_next = cnt_upd;
                        ext_next = ext_upd;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next       = div_quo;
                    res_empty_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase

        out_next = out_reg;
        if (load)
        begin
            out_next.aggregate = res_reg;
            out_next.empty_res = res_empty_reg;
        end
        out_valid_next = load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        res_empty_reg <= res_empty_next;
        out_reg       <= out_next;
    end

    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

endmodule

// File: rtl/depth_window_aggregator_core.sv
// Depth window aggregator: top level with configuration registers.
// Samples are taken one per cycle into a four-word queue while it is not
// full; the back end accumulates one per cycle while in its accumulate
// state. A set ends with its last sample: an empty, maximum or minimum
// result passes from the result register to the output register once the
// output register is free, while a mean first goes through a bit-serial
// divider of SUM_W bits (SUM_W = 32 + log2(MAX_SAMPLES), 48 by default),
// during which the queue keeps taking samples until it fills. The result
// word waits in an output register and the next set is processed meanwhile.
module depth_window_aggregator_core #(
    parameter int MAX_SAMPLES = 65536
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  dwa_pkg::in_word_t           in_data,
    input  logic                        pop,
    output logic                        empty,
    output dwa_pkg::out_word_t          out_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [dwa_pkg::VAL_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = dwa_pkg::VAL_W + $clog2(MAX_SAMPLES);

    dwa_pkg::cfg_t    cfg_reg;
    dwa_pkg::cfg_t    cfg_next;
    logic             queue_full;
    logic             q_push;
    dwa_pkg::qentry_t q_in;
    dwa_pkg::qentry_t q_out;
    logic             q_empty;
    logic             q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dwa_pkg::REG_WINDOW_LOW:   cfg_next.window_low   = $signed(cfg_data);
                dwa_pkg::REG_WINDOW_HIGH:  cfg_next.window_high  = $signed(cfg_data);
                dwa_pkg::REG_AGG_MODE:     cfg_next.agg_mode     = cfg_data[1:0];
                dwa_pkg::REG_NO_DATA_CODE: cfg_next.no_data_code = $signed(cfg_data);
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dwa_front u_front (
        .push       (push),
        .full       (full),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    dwa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (queue_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    dwa_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data)
    );

endmodule

// File: rtl/dwa_checker.sv
// Port-level assertions for the depth window aggregator, bound to the top level.
`include "depth_window_aggregator_core_macros.svh"

module dwa_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input dwa_pkg::out_word_t out_data
);

    // waiting result word holds until taken
    `DWA_CHECK(a_out_hold, !empty && !pop |=> !empty && $stable(out_data), "result word changed while waiting")

    // queue fills only through accepted words
    `DWA_CHECK(a_full_needs_push, $rose(full) |-> $past(push), "full rose without a push")

    // nothing pending and input open while in reset
    `DWA_CHECK_RST(a_reset_state, !rst_n |-> empty && !full, "bad port state in reset")

endmodule

bind depth_window_aggregator_core dwa_checker u_dwa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
);
